>>> rtl/core/pwa_pkg.sv
// Shared types, constants and codes of the power window averager.
`timescale 1ns / 1ps
`default_nettype none

package pwa_pkg;

  // Default sizes of the window state.
  localparam int COUNT_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 32;

  // Register reset values.
  localparam logic [15:0] VOLTAGE_DIVISOR_RST   = 16'd513;
  localparam logic [11:0] CURRENT_OFFSET_RST    = 12'd2092;
  localparam logic [15:0] CURRENT_DIVISOR_RST   = 16'd104;
  localparam logic [15:0] OVERVOLTAGE_LIMIT_RST = 16'd455;
  localparam logic [7:0]  STOP_BELOW_RST        = 8'd147;
  localparam logic [7:0]  START_ABOVE_RST       = 8'd177;

  // Arithmetic constants.
  localparam int VOLT_SCALE    = 100;
  localparam int CURRENT_ROUND = 5;

  // Configuration port widths.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Motor status byte codes.
  localparam logic [7:0] MOTOR_STATUS_RUN  = 8'd0;
  localparam logic [7:0] MOTOR_STATUS_STOP = 8'd1;

  typedef enum logic [2:0] {
    OP_CURRENT = 3'd0,
    OP_VOLTAGE = 3'd1,
    OP_REPORT  = 3'd2,
    OP_ESTOP   = 3'd3,
    OP_MOTOR   = 3'd4
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_VOLTAGE_DIVISOR   = 3'd0,
    CFG_CURRENT_OFFSET    = 3'd1,
    CFG_CURRENT_DIVISOR   = 3'd2,
    CFG_OVERVOLTAGE_LIMIT = 3'd3,
    CFG_STOP_BELOW        = 3'd4,
    CFG_START_ABOVE       = 3'd5
  } cfg_idx_t;

  // The four divisions of a report, run one after another on one divider.
  typedef enum logic [1:0] {
    PH_VOLT_AVG   = 2'd0,
    PH_VOLT_SCALE = 2'd1,
    PH_CURR_AVG   = 2'd2,
    PH_CURR_SCALE = 2'd3
  } div_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] sample_code;
    logic [7:0]  command_byte;
  } pwa_in_t;

  typedef struct packed {
    logic        report_valid;
    logic [15:0] voltage_out;
    logic [15:0] current_out;
    logic        over_voltage;
    logic [15:0] window_count;
    logic        empty_window;
    logic        motor_enabled;
    logic        stop_relay;
  } pwa_out_t;

  typedef struct packed {
    logic       load_item;
    logic       div_start;
    logic       div_capture;
    div_phase_t phase;
    logic       commit;
  } pwa_cmd_t;

  typedef struct packed {
    logic need_divide;
    logic div_done;
  } pwa_status_t;

endpackage

`default_nettype wire

>>> rtl/core/power_window_averager_top.sv
// Top level of the power window averager: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The input channel (in_valid, in_ready, in_data) carries one operation per
// transaction: a current sample, a voltage sample, a report tick, an e-stop
// byte or a motor status byte. Every input transaction yields exactly one
// result transaction on the output channel (out_valid, out_ready, out_data).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per transaction; indexes past the
// last register are ignored. Write it only while the block is idle.
// For samples, e-stop and status bytes the item passes through the decode and
// commit states into the output register, and the block then returns to idle
// to accept the next item. A report tick with samples in the window runs four
// divisions on one shared restoring divider that yields one quotient bit per
// cycle, one division after another, before the commit; a report of an empty
// window skips the divisions and is committed like a sample.
// One item is in work at a time, and the next is accepted once the previous
// result sits in the output register.
// A synchronous active-low reset clears the sums, counter, motor latch and
// output valid, and loads the register defaults. When the receiver stalls,
// the result holds in the output register and the block waits to commit the
// following item until the register is free.

module power_window_averager_top #(
  parameter int COUNT_BITS = pwa_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS   = pwa_pkg::SUM_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire pwa_pkg::pwa_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output pwa_pkg::pwa_out_t                       out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pwa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pwa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pwa_pkg::pwa_cmd_t    cmd;
  pwa_pkg::pwa_status_t status;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  pwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pwa_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/pwa_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pwa_divider #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial     = rem_shift - {1'b0, divisor};
  // The trial difference stays below the divisor when it does not borrow.
  assign fits      = ~trial[DIVISOR_W];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIVIDEND_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt  = fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/pwa_datapath.sv
// Window sums, configuration registers, motor latch, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module pwa_datapath #(
  parameter int COUNT_BITS = pwa_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS   = pwa_pkg::SUM_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pwa_pkg::pwa_in_t                    in_item,
  input  wire logic                                cfg_write,
  input  wire logic [pwa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [pwa_pkg::CFG_DATA_BITS-1:0]   cfg_value,
  input  wire pwa_pkg::pwa_cmd_t                   cmd,
  output pwa_pkg::pwa_status_t                     status,
  output pwa_pkg::pwa_out_t                        result
);

  localparam int DIV_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int WCNT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Configuration registers.
  logic [15:0] vdiv_r, idiv_r, ov_limit_r;
  logic [11:0] ioffset_r;
  logic [7:0]  stop_below_r, start_above_r;

  // Window and motor state.
  logic [SUM_BITS-1:0]   vsum_r, vsum_nxt;
  logic [SUM_BITS-1:0]   isum_r, isum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  motor_r, motor_nxt;
  logic                  latch_r, latch_nxt;
  logic                  relay_r, relay_nxt;

  // Item and report intermediates.
  pwa_pkg::pwa_in_t      item_r;
  logic [SUM_BITS-1:0]   avg_r;
  logic [SUM_BITS-1:0]   volt_r;
  logic [SUM_BITS-1:0]   curr_r;
  pwa_pkg::pwa_out_t     result_r, result_nxt;

  logic [SUM_BITS-1:0]   vprod;
  logic [SUM_BITS-1:0]   icorr;
  logic [SUM_BITS-1:0]   div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic [DIV_W-1:0]      vdiv_eff, idiv_eff;
  logic                  div_done;
  logic [SUM_BITS-1:0]   div_quotient;
  logic                  cnt_zero;
  logic [WCNT_W-1:0]     cnt_wide;

  assign cnt_zero = (cnt_r == '0);
  assign cnt_wide = WCNT_W'(cnt_r);
  assign vprod    = vsum_r * SUM_BITS'(pwa_pkg::VOLT_SCALE);
  assign icorr    = avg_r - SUM_BITS'(ioffset_r) + SUM_BITS'(pwa_pkg::CURRENT_ROUND);
  // A divisor register that holds zero divides by one.
  assign vdiv_eff = (vdiv_r == '0) ? DIV_W'(1) : DIV_W'(vdiv_r);
  assign idiv_eff = (idiv_r == '0) ? DIV_W'(1) : DIV_W'(idiv_r);

  always_comb begin
    unique case (cmd.phase)
      pwa_pkg::PH_VOLT_AVG: begin
        div_dividend = vprod;
        div_divisor  = DIV_W'(cnt_r);
      end
      pwa_pkg::PH_VOLT_SCALE: begin
        div_dividend = avg_r;
        div_divisor  = vdiv_eff;
      end
      pwa_pkg::PH_CURR_AVG: begin
        div_dividend = isum_r;
        div_divisor  = DIV_W'(cnt_r);
      end
      pwa_pkg::PH_CURR_SCALE: begin
        div_dividend = icorr;
        div_divisor  = idiv_eff;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_W'(1);
      end
    endcase
  end

  pwa_divider #(
    .DIVIDEND_W (SUM_BITS),
    .DIVISOR_W  (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign status.need_divide = (item_r.operation == pwa_pkg::OP_REPORT) && !cnt_zero;
  assign status.div_done    = div_done;

  // State update and result of the committed item.
  always_comb begin
    vsum_nxt   = vsum_r;
    isum_nxt   = isum_r;
    cnt_nxt    = cnt_r;
    motor_nxt  = motor_r;
    latch_nxt  = latch_r;
    relay_nxt  = relay_r;
    result_nxt = '0;
    unique case (item_r.operation)
      pwa_pkg::OP_CURRENT: begin
        isum_nxt = isum_r + SUM_BITS'(item_r.sample_code);
      end
      pwa_pkg::OP_VOLTAGE: begin
        isum_nxt = isum_r;
        vsum_nxt = vsum_r + SUM_BITS'(item_r.sample_code);
        cnt_nxt  = cnt_r + COUNT_BITS'(1);
      end
      pwa_pkg::OP_REPORT: begin
        result_nxt.report_valid = 1'b1;
        if (cnt_zero) begin
          result_nxt.empty_window = 1'b1;
        end else begin
          result_nxt.voltage_out  = volt_r[15:0];
          result_nxt.current_out  = curr_r[15:0];
          result_nxt.over_voltage = (volt_r > SUM_BITS'(ov_limit_r));
          result_nxt.window_count = cnt_wide[15:0];
        end
        vsum_nxt = '0;
        isum_nxt = '0;
        cnt_nxt  = '0;
      end
      pwa_pkg::OP_ESTOP: begin
        if (item_r.command_byte < stop_below_r) begin
          relay_nxt = 1'b1;
          motor_nxt = 1'b0;
          latch_nxt = 1'b0;
        end else if (item_r.command_byte > start_above_r && !latch_r) begin
          relay_nxt = 1'b0;
          motor_nxt = 1'b1;
        end
      end
      pwa_pkg::OP_MOTOR: begin
        if (item_r.command_byte == pwa_pkg::MOTOR_STATUS_STOP) begin
          relay_nxt = 1'b1;
          motor_nxt = 1'b0;
          latch_nxt = 1'b1;
        end else if (item_r.command_byte == pwa_pkg::MOTOR_STATUS_RUN && !latch_r) begin
          relay_nxt = 1'b0;
          motor_nxt = 1'b1;
        end
      end
      default: begin
        vsum_nxt = vsum_r;
      end
    endcase
    result_nxt.motor_enabled = motor_nxt;
    result_nxt.stop_relay    = relay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdiv_r        <= pwa_pkg::VOLTAGE_DIVISOR_RST;
      ioffset_r     <= pwa_pkg::CURRENT_OFFSET_RST;
      idiv_r        <= pwa_pkg::CURRENT_DIVISOR_RST;
      ov_limit_r    <= pwa_pkg::OVERVOLTAGE_LIMIT_RST;
      stop_below_r  <= pwa_pkg::STOP_BELOW_RST;
      start_above_r <= pwa_pkg::START_ABOVE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwa_pkg::CFG_VOLTAGE_DIVISOR:   vdiv_r        <= cfg_value;
        pwa_pkg::CFG_CURRENT_OFFSET:    ioffset_r     <= cfg_value[11:0];
        pwa_pkg::CFG_CURRENT_DIVISOR:   idiv_r        <= cfg_value;
        pwa_pkg::CFG_OVERVOLTAGE_LIMIT: ov_limit_r    <= cfg_value;
        pwa_pkg::CFG_STOP_BELOW:        stop_below_r  <= cfg_value[7:0];
        pwa_pkg::CFG_START_ABOVE:       start_above_r <= cfg_value[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r  <= '0;
      isum_r  <= '0;
      cnt_r   <= '0;
      motor_r <= 1'b0;
      latch_r <= 1'b0;
      relay_r <= 1'b0;
    end else if (cmd.commit) begin
      vsum_r  <= vsum_nxt;
      isum_r  <= isum_nxt;
      cnt_r   <= cnt_nxt;
      motor_r <= motor_nxt;
      latch_r <= latch_nxt;
      relay_r <= relay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.div_capture) begin
      unique case (cmd.phase)
        pwa_pkg::PH_VOLT_AVG:   avg_r  <= div_quotient;
        pwa_pkg::PH_VOLT_SCALE: volt_r <= div_quotient;
        pwa_pkg::PH_CURR_AVG:   avg_r  <= div_quotient;
        pwa_pkg::PH_CURR_SCALE: curr_r <= div_quotient;
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

>>> rtl/core/pwa_ctrl.sv
// Sequencing state machine of the power window averager.
`timescale 1ns / 1ps
`default_nettype none

module pwa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pwa_pkg::pwa_status_t status,
  output pwa_pkg::pwa_cmd_t         cmd
);

  pwa_pkg::ctrl_state_t state_r, state_nxt;
  pwa_pkg::div_phase_t  phase_r, phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      pwa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pwa_pkg::ST_DECODE;
        end
      end
      pwa_pkg::ST_DECODE: begin
        phase_nxt = pwa_pkg::PH_VOLT_AVG;
        state_nxt = status.need_divide ? pwa_pkg::ST_DIV_START : pwa_pkg::ST_COMMIT;
      end
      pwa_pkg::ST_DIV_START: begin
        state_nxt = pwa_pkg::ST_DIV_WAIT;
      end
      pwa_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (phase_r == pwa_pkg::PH_CURR_SCALE) begin
            state_nxt = pwa_pkg::ST_COMMIT;
          end else begin
            phase_nxt = pwa_pkg::div_phase_t'(phase_r + 2'd1);
            state_nxt = pwa_pkg::ST_DIV_START;
          end
        end
      end
      pwa_pkg::ST_COMMIT: begin
        if (slot_free) begin
          state_nxt = pwa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pwa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready        = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.div_capture = 1'b0;
    cmd.commit      = 1'b0;
    cmd.phase       = phase_r;
    unique case (state_r)
      pwa_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      pwa_pkg::ST_DECODE: begin
        cmd.phase = pwa_pkg::PH_VOLT_AVG;
      end
      pwa_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      pwa_pkg::ST_DIV_WAIT: begin
        cmd.div_capture = status.div_done;
      end
      pwa_pkg::ST_COMMIT: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwa_pkg::ST_IDLE;
      phase_r     <= pwa_pkg::PH_VOLT_AVG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
